[hw/rtl/gfc_pkg.sv]
// Shared types, constants and lookup functions for the gated frequency counter.
// Used by gated_frequency_counter_bcd_display and tb_top; depends on nothing else.
package gfc_pkg;

    localparam int COUNT_W   = 17;
    localparam int GATE_W    = 24;
    localparam int POS_W     = 4;
    localparam int DIGIT_W   = 4;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT    = 17'd99999;
    localparam logic [GATE_W-1:0]  GATE_RESET     = 24'd1000000;

    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_Z     = 8'h7A;

    // Write positions within one display run
    localparam logic [POS_W-1:0] POS_CLEAR  = 4'd0;
    localparam logic [POS_W-1:0] POS_D4     = 4'd1;
    localparam logic [POS_W-1:0] POS_D3     = 4'd2;
    localparam logic [POS_W-1:0] POS_SPACE1 = 4'd3;
    localparam logic [POS_W-1:0] POS_D2     = 4'd4;
    localparam logic [POS_W-1:0] POS_D1     = 4'd5;
    localparam logic [POS_W-1:0] POS_D0     = 4'd6;
    localparam logic [POS_W-1:0] POS_SPACE2 = 4'd7;
    localparam logic [POS_W-1:0] POS_H      = 4'd8;
    localparam logic [POS_W-1:0] POS_Z      = 4'd9;
    localparam logic [POS_W-1:0] POS_LAST   = POS_Z;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_SEND = 3'b100
    } t_state;

    // Decimal weight of a digit position
    function automatic logic [COUNT_W-1:0] f_pos_weight(input logic [POS_W-1:0] pos);
        logic [COUNT_W-1:0] w;
        unique case (pos)
            POS_D4:  w = 17'd10000;
            POS_D3:  w = 17'd1000;
            POS_D2:  w = 17'd100;
            POS_D1:  w = 17'd10;
            POS_D0:  w = 17'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic f_pos_is_digit(input logic [POS_W-1:0] pos);
        logic d;
        unique case (pos)
            POS_D4, POS_D3, POS_D2, POS_D1, POS_D0: d = 1'b1;
            default:                                d = 1'b0;
        endcase
        return d;
    endfunction

    // Fixed byte for the non-digit positions
    function automatic logic [7:0] f_pos_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            POS_CLEAR:          c = CMD_CLEAR;
            POS_SPACE1, POS_SPACE2: c = CHAR_SPACE;
            POS_H:              c = CHAR_H;
            POS_Z:              c = CHAR_Z;
            default:            c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/gated_frequency_counter_bcd_display.sv]
// Gated frequency counter: edge counting, gate timing and display write sequencer.
// Depends on gfc_pkg.
//
// One signal sample is taken per input transfer and rising edges are counted over
// a gate of gate_ticks samples (a value of 0 acts as 1). A sample that does not
// close the gate leaves the block ready, so samples may arrive back to back.
// On the sample that closes the gate the block stops accepting samples and emits
// ten display writes: clear command, five count digits with a space before the
// hundreds, then space, 'H', 'z', with tlast on the final write. The digits come
// from one shared 17-bit compare-and-subtract unit that peels one decimal weight
// per cycle; a sink stall lengthens the run. tuser carries register_select: 0 for
// the command, 1 for characters.
module gated_frequency_counter_bcd_display (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // gate_ticks register
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] signal_level, [7:1] zero
    // display write stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] lcd_byte
    output logic        m_axis_tuser,   // [0] register_select
    output logic        m_axis_tlast
);

    gfc_pkg::t_state                   r_state, n_state;
    logic [gfc_pkg::GATE_W-1:0]        r_gate_ticks;
    logic                              r_prior_level;
    logic [gfc_pkg::COUNT_W-1:0]       r_edge_count, n_edge_count;
    logic [gfc_pkg::GATE_W-1:0]        r_gate_elapsed, n_gate_elapsed;
    logic [gfc_pkg::COUNT_W-1:0]       r_rest, n_rest;
    logic [gfc_pkg::DIGIT_W-1:0]       r_digit, n_digit;
    logic [gfc_pkg::POS_W-1:0]         r_pos, n_pos;
    logic [7:0]                        r_byte, n_byte;
    logic                              r_rs, n_rs;
    logic                              r_last, n_last;

    logic                              s_fire;
    logic                              level;
    logic                              edge_seen;
    logic [gfc_pkg::GATE_W-1:0]        gate_limit;
    logic [gfc_pkg::GATE_W-1:0]        elapsed_inc;
    logic                              gate_close;
    logic [gfc_pkg::COUNT_W-1:0]       weight;
    logic                              take_weight;

    assign s_axis_tready = (r_state == gfc_pkg::S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign level         = s_axis_tdata[0];
    assign edge_seen     = level && !r_prior_level;
    assign gate_limit    = (r_gate_ticks == '0) ? {{(gfc_pkg::GATE_W-1){1'b0}}, 1'b1}
                                                : r_gate_ticks;
    assign elapsed_inc   = r_gate_elapsed + 1'b1;
    assign gate_close    = (elapsed_inc >= gate_limit) || (elapsed_inc == '0);

    // Shared compare-and-subtract unit
    assign weight        = gfc_pkg::f_pos_weight(r_pos);
    assign take_weight   = gfc_pkg::f_pos_is_digit(r_pos) && (r_rest >= weight);

    assign m_axis_tvalid = (r_state == gfc_pkg::S_SEND);
    assign m_axis_tdata  = r_byte;
    assign m_axis_tuser  = r_rs;
    assign m_axis_tlast  = r_last;

    always_comb begin
        n_state        = r_state;
        n_edge_count   = r_edge_count;
        n_gate_elapsed = r_gate_elapsed;
        n_rest         = r_rest;
        n_digit        = r_digit;
        n_pos          = r_pos;
        n_byte         = r_byte;
        n_rs           = r_rs;
        n_last         = r_last;
        unique case (r_state)
            gfc_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (gate_close) begin
                        // latch the finished count, restart with this tick's edge
                        n_rest         = r_edge_count;
                        n_edge_count   = {{(gfc_pkg::COUNT_W-1){1'b0}}, edge_seen};
                        n_gate_elapsed = '0;
                        n_pos          = gfc_pkg::POS_CLEAR;
                        n_digit        = '0;
                        n_state        = gfc_pkg::S_CONV;
                    end else begin
                        n_gate_elapsed = elapsed_inc;
                        if (edge_seen && (r_edge_count < gfc_pkg::COUNT_LIMIT)) begin
                            n_edge_count = r_edge_count + 1'b1;
                        end
                    end
                end
            end
            gfc_pkg::S_CONV: begin
                if (take_weight) begin
                    n_rest  = r_rest - weight;
                    n_digit = r_digit + 1'b1;
                end else begin
                    if (gfc_pkg::f_pos_is_digit(r_pos)) begin
                        n_byte = gfc_pkg::CHAR_ZERO
                               + {{(8-gfc_pkg::DIGIT_W){1'b0}}, r_digit};
                    end else begin
                        n_byte = gfc_pkg::f_pos_char(r_pos);
                    end
                    n_rs    = (r_pos != gfc_pkg::POS_CLEAR);
                    n_last  = (r_pos == gfc_pkg::POS_LAST);
                    n_state = gfc_pkg::S_SEND;
                end
            end
            gfc_pkg::S_SEND: begin
                if (m_axis_tready) begin
                    if (r_pos == gfc_pkg::POS_LAST) begin
                        n_state = gfc_pkg::S_IDLE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_digit = '0;
                        n_state = gfc_pkg::S_CONV;
                    end
                end
            end
            default: begin
                n_state = gfc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= gfc_pkg::S_IDLE;
            r_gate_ticks   <= gfc_pkg::GATE_RESET;
            r_prior_level  <= 1'b0;
            r_edge_count   <= '0;
            r_gate_elapsed <= '0;
        end else begin
            r_state        <= n_state;
            r_edge_count   <= n_edge_count;
            r_gate_elapsed <= n_gate_elapsed;
            if (s_fire) begin
                r_prior_level <= level;
            end
            if (i_cfg_we) begin
                r_gate_ticks <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_digit <= n_digit;
        r_pos   <= n_pos;
        r_byte  <= n_byte;
        r_rs    <= n_rs;
        r_last  <= n_last;
    end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for gated_frequency_counter_bcd_display.
// Holds its own edge-counting and display-run predictor; depends on gfc_pkg and the RTL.
// Directed table first, then random gates, a stall stretch and one longer gate.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOW_MODEL      = -1;  // expectation from the predictor
    localparam int SHOW_NONE       = -2;  // typed: gate stays open
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 70;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_SAMPLES   = 22;
    localparam int STALL_CYCLES    = 150;
    localparam int LONG_GATE_MIN   = 30;
    localparam int LONG_GATE_MAX   = 40;
    localparam logic [23:0] GATE_MAX = 24'hFFFFFF;

    typedef enum logic [0:0] {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [23:0] value;  // gate length, or signal level in bit 0
        int          shown;  // count shown on this sample, or SHOW_MODEL / SHOW_NONE
    } t_stim_row;

    typedef struct packed {
        logic [7:0] code;
        logic       rs;
        logic       last;
    } t_lcd_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [0] signal_level, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] lcd_byte
    logic        m_axis_tuser;         // [0] register_select
    logic        m_axis_tlast;

    gated_frequency_counter_bcd_display i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state
    logic        pred_prior = 1'b0;
    logic [16:0] pred_edges = '0;
    logic [23:0] pred_elapsed = '0;
    logic [23:0] pred_gate = gfc_pkg::GATE_RESET;

    t_lcd_write pending_writes[$];

    int errors = 0;
    int samples_sent = 0;
    int runs_seen = 0;
    int gate_writes = 0;
    int src_max_gap = 3;
    int sink_max_gap = 3;
    int sink_hold_req = 0;

    t_stim_row directed_rows [20] = '{
        '{ROW_CFG,    24'd0,    SHOW_NONE},   // zero gate acts as one tick
        '{ROW_SAMPLE, 24'd1,    0},           // high first sample counts as an edge
        '{ROW_SAMPLE, 24'd0,    1},
        '{ROW_SAMPLE, 24'd1,    0},
        '{ROW_SAMPLE, 24'd1,    1},
        '{ROW_CFG,    24'd1,    SHOW_NONE},
        '{ROW_SAMPLE, 24'd0,    0},
        '{ROW_CFG,    GATE_MAX, SHOW_NONE},
        '{ROW_SAMPLE, 24'd1,    SHOW_NONE},
        '{ROW_SAMPLE, 24'd0,    SHOW_NONE},
        '{ROW_SAMPLE, 24'd1,    SHOW_NONE},
        '{ROW_SAMPLE, 24'd0,    SHOW_NONE},
        '{ROW_SAMPLE, 24'd1,    SHOW_NONE},
        '{ROW_SAMPLE, 24'd0,    SHOW_NONE},
        '{ROW_CFG,    24'd4,    SHOW_NONE},   // shorter than the time already spent
        '{ROW_SAMPLE, 24'd1,    3},
        '{ROW_CFG,    24'd3,    SHOW_NONE},
        '{ROW_SAMPLE, 24'd0,    SHOW_MODEL},
        '{ROW_SAMPLE, 24'd1,    SHOW_MODEL},
        '{ROW_SAMPLE, 24'd1,    SHOW_MODEL}
    };

    function automatic void add_write(input logic [7:0] code, input logic rs, input logic last);
        t_lcd_write w;
        w.code = code;
        w.rs   = rs;
        w.last = last;
        pending_writes.push_back(w);
    endfunction

    // Expand a count into the ten display writes
    function automatic void queue_display(input logic [16:0] shown);
        logic [16:0] rest;
        logic [16:0] weight;
        logic [16:0] digit;
        int          pos;
        rest   = shown;
        weight = 17'd10000;
        add_write(gfc_pkg::CMD_CLEAR, 1'b0, 1'b0);
        for (pos = 4; pos >= 0; pos--) begin
            digit = rest / weight;
            rest  = rest - digit * weight;
            if (pos == 2)
                add_write(gfc_pkg::CHAR_SPACE, 1'b1, 1'b0);
            add_write(gfc_pkg::CHAR_ZERO + digit[7:0], 1'b1, 1'b0);
            weight = weight / 17'd10;
        end
        add_write(gfc_pkg::CHAR_SPACE, 1'b1, 1'b0);
        add_write(gfc_pkg::CHAR_H, 1'b1, 1'b0);
        add_write(gfc_pkg::CHAR_Z, 1'b1, 1'b1);
    endfunction

    // Advance the edge counter and gate timer by one sample
    function automatic void count_sample(input logic level, output bit closes,
                                         output logic [16:0] shown);
        logic        rise;
        logic [23:0] span;
        rise = level & ~pred_prior;
        span = (pred_gate == '0) ? 24'd1 : pred_gate;
        pred_prior   = level;
        pred_elapsed = pred_elapsed + 24'd1;
        shown  = pred_edges;
        closes = 1'b0;
        if (pred_elapsed >= span || pred_elapsed == '0) begin
            closes       = 1'b1;
            pred_edges   = {16'd0, rise};
            pred_elapsed = '0;
        end else if (rise && pred_edges < gfc_pkg::COUNT_LIMIT) begin
            pred_edges = pred_edges + 17'd1;
        end
    endfunction

    task automatic send_sample(input logic level, input int typed_shown);
        int          gap;
        bit          closes;
        logic [16:0] shown;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, level};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        count_sample(level, closes, shown);
        if (typed_shown == SHOW_MODEL) begin
            if (closes)
                queue_display(shown);
        end else if (typed_shown != SHOW_NONE) begin
            queue_display(17'(typed_shown));
        end
    endtask

    // Hold the sample stream until every expected write has come out
    task automatic drain_display();
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gate(input logic [23:0] ticks);
        drain_display();
        i_cfg_wdata <= ticks;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        pred_gate = ticks;
        gate_writes++;
    endtask

    // Display side: random stalls per transfer, or one long hold when requested
    initial begin : display_sink
        int stall;
        forever begin
            if (sink_hold_req > 0) begin
                stall = sink_hold_req;
                sink_hold_req = 0;
            end else begin
                stall = $urandom_range(0, sink_max_gap);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        t_lcd_write w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected write: expected none, actual byte=%h rs=%b last=%b",
                         $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                w = pending_writes.pop_front();
                if (m_axis_tdata !== w.code) begin
                    errors++;
                    $display("%0t: lcd_byte mismatch: expected %h, actual %h",
                             $realtime, w.code, m_axis_tdata);
                end
                if (m_axis_tuser !== w.rs) begin
                    errors++;
                    $display("%0t: register_select mismatch: expected %b, actual %b",
                             $realtime, w.rs, m_axis_tuser);
                end
                if (m_axis_tlast !== w.last) begin
                    errors++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $realtime, w.last, m_axis_tlast);
                end
                if (w.last)
                    runs_seen++;
            end
        end
    end

    initial begin : stimulus
        logic        level;
        logic [23:0] ticks;
        int          phase;
        int          style;
        int          n;
        level = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_gate(directed_rows[r].value);
            else
                send_sample(directed_rows[r].value[0], directed_rows[r].shown);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       ticks = 24'd0;
                1:       ticks = 24'd1;
                default: ticks = 24'($urandom_range(2, 12));
            endcase
            write_gate(ticks);
            if (phase == 0) begin
                // Stall the display side while samples keep coming back to back
                src_max_gap   = 0;
                sink_hold_req = STALL_CYCLES;
            end else begin
                src_max_gap  = ($urandom_range(0, 2) == 0) ? 0 : 3;
                sink_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 3;
            end
            style = $urandom_range(0, 2);
            for (n = 0; n < PHASE_SAMPLES; n++) begin
                case (style)
                    0:       level = 1'($urandom_range(0, 1));
                    1:       level = ($urandom_range(0, 3) != 0) ? ~level : level;
                    default: level = ($urandom_range(0, 4) == 0) ? ~level : level;
                endcase
                send_sample(level, SHOW_MODEL);
                if ($urandom_range(0, 15) == 0)
                    drain_display();
            end
        end

        // Longer gate: two-digit counts
        src_max_gap  = 3;
        sink_max_gap = 3;
        ticks = 24'($urandom_range(LONG_GATE_MIN, LONG_GATE_MAX));
        write_gate(ticks);
        for (n = 0; n < int'(ticks); n++) begin
            level = ($urandom_range(0, 3) != 0) ? ~level : level;
            send_sample(level, SHOW_MODEL);
        end

        drain_display();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d samples, %0d display runs and %0d gate writes,",
                 samples_sent, runs_seen, gate_writes);
        $display("with zero, one-tick and full-scale gates, a shortened gate and a long sink stall.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(2_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
